// File: rtl/rmst_pkg.sv
// Shared types and constants for the range-maximum segment tree.
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

    // Field widths fixed by the command format.
    localparam int unsigned POS_W = 17;
    localparam int unsigned VAL_W = 32;

    typedef logic        [POS_W-1:0] t_pos;
    typedef logic signed [VAL_W-1:0] t_value;

    // Most negative value: the content of every node after reset.
    localparam t_value INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Status codes.
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // Reset value of the entries-in-use register.
    localparam t_pos ENTRIES_RESET = t_pos'(65536);

endpackage : rmst_pkg

`default_nettype wire

// File: rtl/rmst_store.sv
// Tree node memory with a clearing pass to the most negative value after reset.
`timescale 1ns / 1ps
`default_nettype none

module rmst_store
    import rmst_pkg::*;
#(
    parameter int unsigned DEPTH = 131072,
    parameter int unsigned AW    = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_value        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_value             o_rdata,
    output logic               o_busy
);

    t_value        r_mem [DEPTH];
    t_value        r_rdata;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // The clearing pass walks every node once, one per cycle, after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Single write port, shared between the clearing pass and the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= INT_MIN;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port: data appears the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule : rmst_store

`default_nettype wire

// File: rtl/range_max_segment_tree_core.sv
// Top level of the range-maximum segment tree: command sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// Segment tree of 2*MAX_ENTRIES signed 32-bit nodes held in one memory with a
// single write port and a registered read port, driven by a small sequencer
// that shares one signed maximum unit between writes and queries. After reset
// a clearing pass sets every node to the most negative value; requests are
// held off meanwhile, but configuration writes are taken. One request is
// worked on at a time. A write stores the leaf, then updates each ancestor
// level in turn (log2 of 2*MAX_ENTRIES minus one levels) up to the root. A
// query climbs the tree level by level, with one memory read each for the left
// and the right edge of the range, and closes in the finish state. A rejected
// request goes straight to the finish state. A finished result sits in an
// output register, so the next request may be accepted while it waits.

module range_max_segment_tree_core
    import rmst_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 65536
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    // Configuration port.
    input  wire logic   i_cfg_we,
    input  wire t_pos   i_cfg_wdata,
    // Request channel.
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire logic   i_in_command,
    input  wire t_pos   i_in_position,
    input  wire t_value i_in_value,
    input  wire t_pos   i_in_range_end,
    // Result channel.
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_value      o_out_max_value,
    output logic        o_out_status
);

    localparam int unsigned NODES = 2 * MAX_ENTRIES;
    localparam int unsigned NW    = $clog2(NODES);
    localparam int unsigned HW    = NW + 1;
    localparam int unsigned CW    = (HW > POS_W) ? HW : POS_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_W_LEAF  = 3'd1;
    localparam logic [2:0] S_W_MERGE = 3'd2;
    localparam logic [2:0] S_Q_LO    = 3'd3;
    localparam logic [2:0] S_Q_HI    = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0]    r_state,     n_state;
    t_pos          r_entries;
    logic [NW-1:0] r_k,         n_k;
    logic [HW-1:0] r_lo,        n_lo;
    logic [HW-1:0] r_hi,        n_hi;
    t_value        r_acc,       n_acc;
    logic          r_pend,      n_pend;
    logic          r_query,     n_query;
    logic          r_err,       n_err;
    logic          r_out_valid, n_out_valid;
    t_value        r_out_max,   n_out_max;
    logic          r_out_status, n_out_status;

    logic          w_clr_busy;
    logic          w_mem_we;
    logic [NW-1:0] w_waddr;
    t_value        w_wdata;
    logic [NW-1:0] w_raddr;
    t_value        w_rdata;
    t_value        w_max;
    logic          w_accept;
    logic [CW-1:0] w_pos_c;
    logic [CW-1:0] w_end_c;
    logic [CW-1:0] w_lim_c;
    logic [CW-1:0] w_first_leaf;
    logic [CW-1:0] w_last_excl;
    logic          w_pos_ok;
    logic          w_end_ok;
    logic [NW-1:0] w_k_up;
    logic [HW-1:0] w_hi_dec;

    // Node memory with its clearing pass.
    rmst_store #(
        .DEPTH (NODES),
        .AW    (NW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata),
        .o_busy  (w_clr_busy)
    );

    // The shared maximum unit: running value against the word just read.
    assign w_max = (w_rdata > r_acc) ? w_rdata : r_acc;

    // Request acceptance and index checks against the smaller of both limits.
    assign o_in_stall = w_clr_busy || (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_pos_c = CW'(i_in_position);
    assign w_end_c = CW'(i_in_range_end);
    assign w_lim_c = (CW'(r_entries) < MAX_C) ? CW'(r_entries) : MAX_C;
    assign w_pos_ok = (w_pos_c != '0) && (w_pos_c <= w_lim_c);
    assign w_end_ok = (w_end_c != '0) && (w_end_c <= w_lim_c);

    assign w_first_leaf = MAX_C + w_pos_c - CW'(1);
    assign w_last_excl  = MAX_C + w_end_c;

    assign w_k_up   = r_k >> 1;
    assign w_hi_dec = r_hi - HW'(1);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_acc        = r_acc;
        n_pend       = r_pend;
        n_query      = r_query;
        n_err        = r_err;
        n_out_valid  = r_out_valid;
        n_out_max    = r_out_max;
        n_out_status = r_out_status;
        w_mem_we     = 1'b0;
        w_waddr      = r_k;
        w_wdata      = r_acc;
        w_raddr      = r_k ^ NW'(1);

        // A word read for a query on the previous cycle joins the running maximum.
        if (r_pend) begin
            n_acc = w_max;
        end

        // The waiting result leaves when the far side takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_query = (i_in_command == CMD_QUERY);
                    n_pend  = 1'b0;
                    if (i_in_command == CMD_QUERY) begin
                        if (w_pos_ok && w_end_ok && (w_pos_c <= w_end_c)) begin
                            n_err   = 1'b0;
                            n_lo    = w_first_leaf[HW-1:0];
                            n_hi    = w_last_excl[HW-1:0];
                            n_acc   = INT_MIN;
                            n_state = S_Q_LO;
                        end else begin
                            n_err   = 1'b1;
                            n_state = S_FINISH;
                        end
                    end else begin
                        if (w_pos_ok) begin
                            n_err   = 1'b0;
                            n_k     = w_first_leaf[NW-1:0];
                            n_acc   = i_in_value;
                            n_state = S_W_LEAF;
                        end else begin
                            n_err   = 1'b1;
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_W_LEAF: begin
                // Store the leaf and fetch its sibling in the same cycle.
                w_mem_we = 1'b1;
                if (r_k == NW'(1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_W_MERGE;
                end
            end
            S_W_MERGE: begin
                // Parent takes the larger of the pair; fetch the parent's sibling.
                n_acc    = w_max;
                w_mem_we = 1'b1;
                w_waddr  = w_k_up;
                w_wdata  = w_max;
                w_raddr  = w_k_up ^ NW'(1);
                n_k      = w_k_up;
                if (w_k_up == NW'(1)) begin
                    n_state = S_FINISH;
                end
            end
            S_Q_LO: begin
                // Left edge: a right child is taken whole and the edge moves on.
                if (r_lo < r_hi) begin
                    w_raddr = r_lo[NW-1:0];
                    n_pend  = r_lo[0];
                    if (r_lo[0]) begin
                        n_lo = r_lo + HW'(1);
                    end
                    n_state = S_Q_HI;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FINISH;
                end
            end
            S_Q_HI: begin
                // Right edge: a left neighbour is taken whole, then both edges climb.
                w_raddr = w_hi_dec[NW-1:0];
                n_pend  = r_hi[0];
                n_hi    = (r_hi[0] ? w_hi_dec : r_hi) >> 1;
                n_lo    = r_lo >> 1;
                n_state = S_Q_LO;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_err ? ST_ERROR : ST_DONE;
                    n_out_max    = (r_query && !r_err) ? r_acc : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_entries   <= ENTRIES_RESET;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_acc        <= n_acc;
        r_query      <= n_query;
        r_err        <= n_err;
        r_out_max    <= n_out_max;
        r_out_status <= n_out_status;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_max_value = r_out_max;
    assign o_out_status    = r_out_status;

`ifndef NO_ASSERTIONS
    // The sequencer never writes the memory while the clearing pass owns it.
    a_no_write_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !w_mem_we)
        else $error("node write issued during the clearing pass");

    // An accepted request always leaves the idle state.
    a_accept_leaves_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // The left edge of a query never passes the right edge mid-level.
    a_query_edges_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_HI) |-> (r_lo <= r_hi))
        else $error("query left edge passed the right edge");

    // A rejected request reports a zero maximum.
    a_error_zero_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status == ST_ERROR)) |-> (o_out_max_value == '0))
        else $error("error result carries a non-zero maximum");
`endif

endmodule : range_max_segment_tree_core

`default_nettype wire

// File: tb/tb_range_max_segment_tree_core.sv
// Self-checking testbench for the range-maximum segment tree core.
`timescale 1ns / 1ps

module tb_range_max_segment_tree_core;
    import rmst_pkg::*;

    localparam int unsigned TREE_LEAVES = 65536;
    localparam int unsigned N_PHASES    = 9;
    // Register settings after the directed part, and random requests per setting.
    localparam int unsigned PHASE_ENTRIES [N_PHASES] =
        '{16, 1, 0, 131071, 300, 65535, 2, 65536, 5000};
    localparam int unsigned PHASE_ITEMS [N_PHASES] =
        '{180, 120, 30, 220, 200, 200, 100, 250, 230};

    typedef struct {
        logic   command;
        t_pos   position;
        t_value value;
        t_pos   range_end;
    } t_request;

    typedef struct {
        t_value max_value;
        logic   status;
    } t_reply;

    // Clock, reset and block inputs, all at known values from time zero.
    logic   i_clk           = 1'b0;
    logic   i_rst_n         = 1'b0;
    logic   i_cfg_we        = 1'b0;
    t_pos   i_cfg_wdata     = ENTRIES_RESET;
    logic   i_in_valid      = 1'b0;
    logic   i_in_command    = CMD_WRITE;
    t_pos   i_in_position   = '0;
    t_value i_in_value      = '0;
    t_pos   i_in_range_end  = '0;
    logic   i_out_stall     = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_value o_out_max_value;
    logic   o_out_status;

    // Shadow copy of the tree and the register.
    t_value node_max [0:2*TREE_LEAVES-1];
    t_pos   entries_now = ENTRIES_RESET;

    t_request queued_requests [$];
    t_reply   awaited_replies [$];

    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    bit          calm_send  = 1'b0;
    bit          calm_recv  = 1'b0;
    int unsigned hot_lo     = 1;
    int unsigned hot_span   = 1;

    int unsigned mismatches = 0;
    int unsigned n_writes   = 0;
    int unsigned n_queries  = 0;
    int unsigned n_rejected = 0;
    int unsigned n_replies  = 0;

    range_max_segment_tree_core #(
        .MAX_ENTRIES(TREE_LEAVES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_command   (i_in_command),
        .i_in_position  (i_in_position),
        .i_in_value     (i_in_value),
        .i_in_range_end (i_in_range_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_max_value(o_out_max_value),
        .o_out_status   (o_out_status)
    );

    always #4 i_clk = ~i_clk;

    // Highest position the current register setting lets through.
    function automatic int unsigned pos_limit();
        return (entries_now < TREE_LEAVES) ? int'(entries_now) : TREE_LEAVES;
    endfunction

    // Applies one request to the shadow tree and returns the reply it should give.
    function automatic t_reply tree_reply(t_request rq);
        t_reply      rp;
        int unsigned lim;
        int unsigned k;
        int unsigned lo;
        int unsigned hi;
        t_value      best;
        rp.max_value = '0;
        rp.status    = ST_DONE;
        lim = pos_limit();
        if (rq.command == CMD_WRITE) begin
            if (rq.position >= 1 && rq.position <= lim) begin
                // Set the leaf, then refresh every ancestor up to the root.
                k = TREE_LEAVES + rq.position - 1;
                node_max[k] = rq.value;
                while (k > 1) begin
                    k = k >> 1;
                    node_max[k] = (node_max[2*k] > node_max[2*k+1]) ?
                                  node_max[2*k] : node_max[2*k+1];
                end
            end else begin
                rp.status = ST_ERROR;
            end
        end else begin
            if (rq.position >= 1 && rq.range_end >= 1 && rq.position <= lim &&
                rq.range_end <= lim && rq.position <= rq.range_end) begin
                // Climb from both edges of the half-open leaf span.
                lo   = TREE_LEAVES + rq.position - 1;
                hi   = TREE_LEAVES + rq.range_end;
                best = INT_MIN;
                while (lo < hi) begin
                    if (lo[0]) begin
                        if (node_max[lo] > best) best = node_max[lo];
                        lo = lo + 1;
                    end
                    if (hi[0]) begin
                        hi = hi - 1;
                        if (node_max[hi] > best) best = node_max[hi];
                    end
                    lo = lo >> 1;
                    hi = hi >> 1;
                end
                rp.max_value = best;
            end else begin
                rp.status = ST_ERROR;
            end
        end
        return rp;
    endfunction

    function automatic t_request make_cmd(logic cmd, int unsigned pos, t_value val,
                                          int unsigned last);
        t_request rq;
        rq.command   = cmd;
        rq.position  = t_pos'(pos);
        rq.value     = val;
        rq.range_end = t_pos'(last);
        return rq;
    endfunction

    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic t_value random_value();
        case ($urandom_range(0, 7))
            0: return INT_MIN;
            1: return t_value'(32'h7FFF_FFFF);
            2: return t_value'(int'($urandom_range(0, 200)) - 100);
            default: return t_value'($urandom);
        endcase
    endfunction

    // Valid position, biased towards the edges and a small hot window.
    function automatic int unsigned pick_position(int unsigned lim);
        case ($urandom_range(0, 9))
            0: return 1;
            1: return lim;
            2, 3, 4: return $urandom_range(1, lim);
            default: return hot_lo + $urandom_range(0, hot_span - 1);
        endcase
    endfunction

    function automatic int unsigned bad_position(int unsigned lim);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return lim + 1;
            default: return $urandom_range(lim + 1, 131071);
        endcase
    endfunction

    // Mostly well-formed requests inside the limit, with some malformed ones.
    function automatic t_request random_request();
        t_request    rq;
        int unsigned lim;
        int unsigned a;
        int unsigned b;
        lim = pos_limit();
        rq.command   = $urandom_range(0, 1) ? CMD_QUERY : CMD_WRITE;
        rq.value     = random_value();
        rq.range_end = t_pos'($urandom);
        rq.position  = t_pos'($urandom);
        if (lim == 0) return rq;
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 2))
                0: rq.position = t_pos'(bad_position(lim));
                1: begin
                    rq.command   = CMD_QUERY;
                    rq.position  = t_pos'(pick_position(lim));
                    rq.range_end = t_pos'(bad_position(lim));
                end
                default: begin
                    // Reversed range: start above end.
                    rq.command = CMD_QUERY;
                    a = pick_position(lim);
                    b = pick_position(lim);
                    if (a < b) begin
                        a = a ^ b;
                        b = a ^ b;
                        a = a ^ b;
                    end
                    if (a == b) begin
                        if (a < lim) a = a + 1;
                        else b = b - 1;
                    end
                    rq.position  = t_pos'(a);
                    rq.range_end = t_pos'(b);
                end
            endcase
        end else begin
            a = pick_position(lim);
            b = ($urandom_range(0, 7) == 0) ? a : pick_position(lim);
            if (rq.command == CMD_QUERY) begin
                rq.position  = t_pos'((a < b) ? a : b);
                rq.range_end = t_pos'((a < b) ? b : a);
            end else begin
                rq.position = t_pos'(a);
            end
        end
        return rq;
    endfunction

    // Waits until no request is queued, on the channel or awaiting its reply.
    task automatic drain_requests();
        while (queued_requests.size() != 0 || i_in_valid || awaited_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: predicts on acceptance, then presents the next request.
    always @(posedge i_clk) begin : drive_requests
        t_request taken;
        t_request next_req;
        t_reply   rp;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                taken = make_cmd(i_in_command, i_in_position, i_in_value, i_in_range_end);
                rp    = tree_reply(taken);
                awaited_replies.push_back(rp);
                if (rp.status == ST_ERROR) n_rejected++;
                else if (taken.command == CMD_WRITE) n_writes++;
                else n_queries++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    i_in_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (queued_requests.size() != 0) begin
                    next_req = queued_requests.pop_front();
                    i_in_valid     <= 1'b1;
                    i_in_command   <= next_req.command;
                    i_in_position  <= next_req.position;
                    i_in_value     <= next_req.value;
                    i_in_range_end <= next_req.range_end;
                    send_gap       <= draw_wait(calm_send);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: checks each taken reply and stalls for a drawn number of cycles.
    always @(posedge i_clk) begin : check_replies
        t_reply      want;
        int unsigned hold;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            hold = stall_left;
            if (o_out_valid && !i_out_stall) begin
                n_replies++;
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply %0d arrived with none outstanding: max %0d status %0d",
                                 n_replies, o_out_max_value, o_out_status);
                end else begin
                    want = awaited_replies.pop_front();
                    if (o_out_max_value !== want.max_value || o_out_status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("reply %0d: expected max %0d status %0d, got max %0d status %0d",
                                     n_replies, want.max_value, want.status,
                                     o_out_max_value, o_out_status);
                    end
                end
                hold = draw_wait(calm_recv);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= hold - 1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left  <= 0;
            end
        end
    end

    // Main sequence: reset, directed requests, then random phases per register setting.
    initial begin
        int unsigned lim;
        for (int i = 0; i < 2 * TREE_LEAVES; i++) node_max[i] = INT_MIN;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests at the reset setting: extremes, rejects and ignored fields.
        queued_requests.push_back(make_cmd(CMD_QUERY, 1, 0, 65536));
        queued_requests.push_back(make_cmd(CMD_WRITE, 1, t_value'(32'h7FFF_FFFF), 0));
        queued_requests.push_back(make_cmd(CMD_WRITE, 65536, INT_MIN, 0));
        queued_requests.push_back(make_cmd(CMD_WRITE, 2, t_value'(-1), 0));
        queued_requests.push_back(make_cmd(CMD_WRITE, 65535, t_value'(0), 0));
        queued_requests.push_back(make_cmd(CMD_QUERY, 1, 0, 65536));
        queued_requests.push_back(make_cmd(CMD_QUERY, 2, 0, 65536));
        queued_requests.push_back(make_cmd(CMD_QUERY, 65536, 0, 65536));
        queued_requests.push_back(make_cmd(CMD_QUERY, 1, 0, 1));
        queued_requests.push_back(make_cmd(CMD_WRITE, 0, t_value'(5), 0));
        queued_requests.push_back(make_cmd(CMD_WRITE, 65537, t_value'(5), 0));
        queued_requests.push_back(make_cmd(CMD_WRITE, 131071, t_value'(-1), 131071));
        queued_requests.push_back(make_cmd(CMD_QUERY, 0, 0, 10));
        queued_requests.push_back(make_cmd(CMD_QUERY, 10, 0, 0));
        queued_requests.push_back(make_cmd(CMD_QUERY, 10, 0, 5));
        queued_requests.push_back(make_cmd(CMD_QUERY, 1, 0, 65537));
        queued_requests.push_back(make_cmd(CMD_QUERY, 131071, 0, 131071));
        queued_requests.push_back(make_cmd(CMD_WRITE, 40000, t_value'(12345), 131071));
        queued_requests.push_back(make_cmd(CMD_QUERY, 3, t_value'(-1), 65534));
        queued_requests.push_back(make_cmd(CMD_QUERY, 40000, INT_MIN, 40000));
        queued_requests.push_back(make_cmd(CMD_WRITE, 2, INT_MIN, 0));
        queued_requests.push_back(make_cmd(CMD_QUERY, 2, 0, 3));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_requests();
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= t_pos'(PHASE_ENTRIES[ph]);
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            entries_now = t_pos'(PHASE_ENTRIES[ph]);

            // Place the hot window and decide whether either side runs without gaps.
            lim = pos_limit();
            if (lim <= 64) begin
                hot_lo   = 1;
                hot_span = (lim == 0) ? 1 : lim;
            end else begin
                hot_lo   = $urandom_range(1, lim - 63);
                hot_span = 64;
            end
            calm_send = ($urandom_range(0, 2) == 0);
            calm_recv = ($urandom_range(0, 2) == 0);

            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
                queued_requests.push_back(random_request());
        end

        drain_requests();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d writes, %0d queries and %0d rejected requests over %0d settings;",
                 n_writes, n_queries, n_rejected, N_PHASES + 1);
        $display("%0d replies checked, %0d mismatches.", n_replies, mismatches);
        if (mismatches == 0)
            $display("[range_max_segment_tree_core] OK");
        else
            $display("[range_max_segment_tree_core] ERROR");
        $finish;
    end

    // Watchdog: allows for the clearing pass and the slowest handshakes several times over.
    initial begin
        #10_000_000;
        $display("[range_max_segment_tree_core] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/rmst_pkg.sv
rtl/rmst_store.sv
rtl/range_max_segment_tree_core.sv
tb/tb_range_max_segment_tree_core.sv
